// ----- hw/rtl/skset_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package skset_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_BITS = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int SIZE_W   = 11;
    localparam int GRP_SIZE = 32;
    localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    typedef logic [1:0] t_op;
    localparam t_op OP_MEMBER = 2'd0;
    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_DELETE = 2'd2;

    typedef logic [1:0] t_code;
    localparam t_code CODE_MISS = 2'd0;
    localparam t_code CODE_HIT  = 2'd1;
    localparam t_code CODE_FULL = 2'd2;

    typedef struct packed {
        t_op         op;
        logic [15:0] key;
    } t_in_item;

    typedef struct packed {
        t_code             result_code;
        logic [SIZE_W-1:0] set_size;
    } t_out_item;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_DELETE
    } t_shift;

    typedef struct packed {
        logic                load;
        t_shift              shift;
        logic [KEY_BITS-1:0] key;
    } t_cell_ctl;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_key_set.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// -------   ------------------   ---------------------------------
// command   start / busy         i_in  : op, key
// result    o_valid (strobe)     o_out : result_code, set_size
//
// The accepting edge compares the key against all cells and registers the
// per-cell ordering flags and the grouped match flags; in the apply state
// that follows, the groups are reduced, the cell row shifts and the result
// is registered and shown for one cycle while the next word can be accepted.
// Synchronous reset empties the set; cell contents are left as they are.
// The receiver cannot stall, so a result is never held back.

module sorted_key_set import skset_pkg::*; (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      start,
    input  t_in_item i_in,
    output logic     busy,
    output logic     o_valid,
    output t_out_item o_out
);

    t_state              r_state;
    t_state              n_state;
    t_op                 r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;
    logic [NUM_GRP-1:0]  r_grp_eq;
    logic [NUM_GRP-1:0]  n_grp_eq;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                w_accept;
    logic                w_present;
    logic                w_full;
    t_shift              w_shift;
    t_code               w_code;
    t_cell_ctl           w_ctl;

    logic [KEY_BITS-1:0]         w_key [CAPACITY];
    logic [CAPACITY-1:0]         w_lt;
    logic [CAPACITY-1:0]         w_eq;
    logic [NUM_GRP*GRP_SIZE-1:0] w_eq_pad;

    assign busy     = (r_state == ST_APPLY);
    assign w_accept = start && !busy;

    assign w_ctl.load  = w_accept;
    assign w_ctl.shift = w_shift;
    assign w_ctl.key   = w_accept ? KEY_BITS'(i_in.key) : r_key;

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        logic                w_valid;
        logic                w_prev_lt;
        logic [KEY_BITS-1:0] w_prev_key;
        logic [KEY_BITS-1:0] w_next_key;

        assign w_valid = (COUNT_W'(c) < r_count);

        if (c == 0) begin : g_first
            assign w_prev_lt  = 1'b1;
            assign w_prev_key = w_ctl.key;
        end else begin : g_inner
            assign w_prev_lt  = w_lt[c-1];
            assign w_prev_key = w_key[c-1];
        end

        if (c == CAPACITY - 1) begin : g_last
            assign w_next_key = w_key[c];
        end else begin : g_body
            assign w_next_key = w_key[c+1];
        end

        skset_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_valid    (w_valid),
            .i_prev_lt  (w_prev_lt),
            .i_prev_key (w_prev_key),
            .i_next_key (w_next_key),
            .o_key      (w_key[c]),
            .o_lt       (w_lt[c]),
            .o_eq       (w_eq[c])
        );
    end

    if (NUM_GRP * GRP_SIZE > CAPACITY) begin : g_pad
        assign w_eq_pad = {{(NUM_GRP * GRP_SIZE - CAPACITY){1'b0}}, w_eq};
    end else begin : g_nopad
        assign w_eq_pad = w_eq;
    end

    // First level of the match reduction is registered with the ordering flags.
    for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
        assign n_grp_eq[g] = |w_eq_pad[g*GRP_SIZE +: GRP_SIZE];
    end

    assign w_present = |r_grp_eq;
    assign w_full    = (r_count >= COUNT_W'(CAPACITY));

    always_comb begin
        unique case (r_state)
            ST_IDLE:  n_state = w_accept ? ST_APPLY : ST_IDLE;
            ST_APPLY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_shift = SH_HOLD;
        w_code  = CODE_MISS;
        n_count = r_count;
        if (r_state == ST_APPLY) begin
            unique case (r_op)
                OP_MEMBER: begin
                    w_code = w_present ? CODE_HIT : CODE_MISS;
                end
                OP_INSERT: begin
                    // The duplicate check takes precedence over the full check.
                    if (w_present) begin
                        w_code = CODE_MISS;
                    end else if (w_full) begin
                        w_code = CODE_FULL;
                    end else begin
                        w_shift = SH_INSERT;
                        w_code  = CODE_HIT;
                        n_count = r_count + COUNT_W'(1);
                    end
                end
                OP_DELETE: begin
                    if (w_present) begin
                        w_shift = SH_DELETE;
                        w_code  = CODE_HIT;
                        n_count = r_count - COUNT_W'(1);
                    end
                end
                default: begin
                    w_code = CODE_MISS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= (r_state == ST_APPLY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_in.op;
            r_key    <= KEY_BITS'(i_in.key);
            r_grp_eq <= n_grp_eq;
        end
        if (r_state == ST_APPLY) begin
            r_out.result_code <= w_code;
            r_out.set_size    <= SIZE_W'(n_count);
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/skset_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module skset_cell import skset_pkg::*; (
    input  wire                 i_clk,
    input  t_cell_ctl           i_ctl,
    input  wire                 i_valid,
    input  wire                 i_prev_lt,
    input  wire [KEY_BITS-1:0]  i_prev_key,
    input  wire [KEY_BITS-1:0]  i_next_key,
    output logic [KEY_BITS-1:0] o_key,
    output logic                o_lt,
    output logic                o_eq
);

    logic [KEY_BITS-1:0] r_key;
    logic [KEY_BITS-1:0] n_key;
    logic                r_lt;
    logic                n_lt;

    always_comb begin
        n_lt = r_lt;
        if (i_ctl.load) begin
            n_lt = i_valid && (r_key < i_ctl.key);
        end
    end

    // Cells holding keys below the target keep them; the rest move one place
    // up for an insert (the boundary cell takes the new key) or down for a delete.
    always_comb begin
        unique case (i_ctl.shift)
            SH_HOLD: begin
                n_key = r_key;
            end
            SH_INSERT: begin
                if (r_lt) begin
                    n_key = r_key;
                end else if (i_prev_lt) begin
                    n_key = i_ctl.key;
                end else begin
                    n_key = i_prev_key;
                end
            end
            SH_DELETE: begin
                n_key = r_lt ? r_key : i_next_key;
            end
            default: begin
                n_key = r_key;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_lt  <= n_lt;
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = i_valid && (r_key == i_ctl.key);

endmodule

`default_nettype wire

// ----- hw/rtl/skset_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none

module skset_chk import skset_pkg::*; (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input t_in_item  i_in,
    input wire       busy,
    input wire       o_valid,
    input t_out_item o_out
);

    // An accepted word always occupies the block for the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A busy cycle is always followed by a result, with busy low again.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("busy word did not produce a result");

    // A result appears only after a busy cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding busy cycle");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out.result_code == CODE_MISS || o_out.result_code == CODE_HIT ||
                     o_out.result_code == CODE_FULL))
        else $error("illegal result code");

endmodule

bind sorted_key_set skset_chk u_skset_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_in    (i_in),
    .busy    (busy),
    .o_valid (o_valid),
    .o_out   (o_out)
);

`default_nettype wire
